// ===== rtl/core/ccrgb_pkg.sv =====
// shared types, codes and constants of the crop and rgb888 conversion block
`default_nettype none

package ccrgb_pkg;

    localparam int DIM_W   = 13;
    localparam int CNT_W   = 12;
    localparam int MAX_DIM = 4096;
    localparam int CALC_W  = 20;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CROP_LEFT    = 3'd2;
    localparam logic [2:0] REG_CROP_TOP     = 3'd3;
    localparam logic [2:0] REG_CROP_RIGHT   = 3'd4;
    localparam logic [2:0] REG_CROP_BOTTOM  = 3'd5;
    localparam logic [2:0] REG_PIXEL_FORMAT = 3'd6;

    typedef enum logic [1:0] {
        FMT_RGB  = 2'd0,
        FMT_BGRA = 2'd1,
        FMT_YUV  = 2'd2,
        FMT_GRAY = 2'd3
    } t_ccrgb_fmt;

    typedef logic signed [CALC_W-1:0] t_calc;

    localparam t_calc K_Y   = 20'sd298;
    localparam t_calc K_RV  = 20'sd409;
    localparam t_calc K_GU  = 20'sd100;
    localparam t_calc K_GV  = 20'sd208;
    localparam t_calc K_BU  = 20'sd516;
    localparam t_calc K_RND = 20'sd128;
    localparam logic [7:0] Y_FLOOR = 8'd16;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [CNT_W-1:0] crop_left;
        logic [CNT_W-1:0] crop_top;
        logic [DIM_W-1:0] crop_right;
        logic [DIM_W-1:0] crop_bottom;
        t_ccrgb_fmt       pixel_format;
    } t_ccrgb_cfg;

    // one pixel inside the window, waiting for conversion
    typedef struct packed {
        logic       last;
        t_ccrgb_fmt fmt;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_ccrgb_item;

endpackage

`default_nettype wire

// ===== rtl/core/ccrgb_front.sv =====
// front end: raster counters, crop window test and item classification
`default_nettype none

module ccrgb_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  ccrgb_pkg::t_ccrgb_cfg     i_cfg,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire                       i_frame_start,
    input  wire  [7:0]                i_a,
    input  wire  [7:0]                i_b,
    input  wire  [7:0]                i_c,
    input  wire                       i_full,
    output logic                      o_push,
    output ccrgb_pkg::t_ccrgb_item    o_item
);
    import ccrgb_pkg::*;

    typedef struct packed {
        logic [DIM_W-1:0] lo;
        logic [DIM_W-1:0] hi;
    } t_span;

    function automatic logic [DIM_W-1:0] dim_limit(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    function automatic t_span span_of(input logic [DIM_W-1:0] size,
                                      input logic [DIM_W-1:0] lo_in,
                                      input logic [DIM_W-1:0] hi_in);
        t_span            s;
        logic [DIM_W-1:0] l1;
        l1 = (lo_in < size - 1'b1) ? lo_in : size - 1'b1;
        s.hi = hi_in;
        if (s.hi < l1 + 1'b1) begin
            s.hi = l1 + 1'b1;
        end
        if (s.hi > size) begin
            s.hi = size;
        end
        s.lo = l1;
        return s;
    endfunction

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] w, h, col1, row1;
    logic [CNT_W-1:0] col0, row0;
    t_span            sx, sy;
    logic             in_win, accept;

    always_comb begin
        w  = dim_limit(i_cfg.frame_width);
        h  = dim_limit(i_cfg.frame_height);
        sx = span_of(w, {1'b0, i_cfg.crop_left}, i_cfg.crop_right);
        sy = span_of(h, {1'b0, i_cfg.crop_top}, i_cfg.crop_bottom);

        // a frame start puts this item at column 0, row 0
        col0 = i_frame_start ? '0 : r_col;
        row0 = i_frame_start ? '0 : r_row;
        col1 = {1'b0, col0} + 1'b1;
        row1 = {1'b0, row0} + 1'b1;

        in_win = ({1'b0, col0} >= sx.lo) && ({1'b0, col0} < sx.hi) &&
                 ({1'b0, row0} >= sy.lo) && ({1'b0, row0} < sy.hi);

        o_ready = !i_full;
        accept  = i_valid && o_ready;
        o_push  = accept && in_win;

        o_item.last = (col1 == sx.hi) && (row1 == sy.hi);
        o_item.fmt  = i_cfg.pixel_format;
        o_item.a    = i_a;
        o_item.b    = i_b;
        o_item.c    = i_c;

        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col1 >= w) begin
                n_col = '0;
                n_row = (row1 >= h) ? '0 : row1[CNT_W-1:0];
            end else begin
                n_col = col1[CNT_W-1:0];
                n_row = row0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ccrgb_fifo.sv =====
// short item queue between the front end and the conversion pipeline
`default_nettype none

module ccrgb_fifo #(
    parameter int DEPTH = ccrgb_pkg::FIFO_DEPTH_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_push,
    input  ccrgb_pkg::t_ccrgb_item    i_item,
    input  wire                       i_pop,
    output ccrgb_pkg::t_ccrgb_item    o_item,
    output logic                      o_full,
    output logic                      o_empty
);
    import ccrgb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_ccrgb_item      r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        o_full  = (r_count == CW'(DEPTH));
        o_empty = (r_count == '0);
        o_item  = r_mem[r_rd_ptr];

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end

        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count lost an item");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ccrgb_back.sv =====
// back end: two-stage colour conversion, product stage then output register
`default_nettype none

module ccrgb_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_empty,
    input  ccrgb_pkg::t_ccrgb_item    i_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic [7:0]                o_red,
    output logic [7:0]                o_green,
    output logic [7:0]                o_blue,
    output logic                      o_last
);
    import ccrgb_pkg::*;

    function automatic logic [7:0] clamp_byte(input t_calc v);
        logic [7:0] r;
        if (v < 0) begin
            r = 8'd0;
        end else if (v[CALC_W-1:8] > (CALC_W-8)'(255)) begin
            r = 8'd255;
        end else begin
            r = v[15:8];
        end
        return r;
    endfunction

    logic        advance;

    // stage 1: products
    logic        r_s1_valid;
    t_ccrgb_item r_s1_item;
    t_calc       r_py, r_prv, r_pgu, r_pgv, r_pbu;
    t_calc       n_py, n_prv, n_pgu, n_pgv, n_pbu;
    logic [7:0]  cy;
    t_calc       dd, ee;

    // stage 2: sums, clamp and format select
    logic        r_out_valid;
    logic [7:0]  r_red, r_green, r_blue;
    logic        r_last;
    logic [7:0]  n_red, n_green, n_blue;
    t_calc       sum_r, sum_g, sum_b;

    always_comb begin
        advance = !r_out_valid || i_ready;
        o_pop   = !i_empty && advance;

        cy = (i_item.a < Y_FLOOR) ? 8'd0 : i_item.a - Y_FLOOR;
        dd = t_calc'($signed({~i_item.b[7], i_item.b[6:0]}));
        ee = t_calc'($signed({~i_item.c[7], i_item.c[6:0]}));

        n_py  = t_calc'($signed({1'b0, cy})) * K_Y;
        n_prv = ee * K_RV;
        n_pgu = dd * K_GU;
        n_pgv = ee * K_GV;
        n_pbu = dd * K_BU;

        sum_r = r_py + r_prv + K_RND;
        sum_g = r_py - r_pgu - r_pgv + K_RND;
        sum_b = r_py + r_pbu + K_RND;

        case (r_s1_item.fmt)
            FMT_RGB: begin
                n_red   = r_s1_item.a;
                n_green = r_s1_item.b;
                n_blue  = r_s1_item.c;
            end
            FMT_BGRA: begin
                n_red   = r_s1_item.c;
                n_green = r_s1_item.b;
                n_blue  = r_s1_item.a;
            end
            FMT_YUV: begin
                n_red   = clamp_byte(sum_r);
                n_green = clamp_byte(sum_g);
                n_blue  = clamp_byte(sum_b);
            end
            FMT_GRAY: begin
                n_red   = r_s1_item.a;
                n_green = r_s1_item.a;
                n_blue  = r_s1_item.a;
            end
            default: begin
                n_red   = r_s1_item.a;
                n_green = r_s1_item.a;
                n_blue  = r_s1_item.a;
            end
        endcase

        o_valid = r_out_valid;
        o_red   = r_red;
        o_green = r_green;
        o_blue  = r_blue;
        o_last  = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_item <= i_item;
            r_py      <= n_py;
            r_prv     <= n_prv;
            r_pgu     <= n_pgu;
            r_pgv     <= n_pgv;
            r_pbu     <= n_pbu;
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
            r_last    <= r_s1_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= o_pop;
            r_out_valid <= r_s1_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/crop_and_convert_to_rgb888.sv =====
// Crop-and-convert pixel stream block, top level.
// The slave stream takes one source pixel per item in raster order; tuser
// flags the first pixel of a frame and clears the column and row counters.
// Only pixels inside the crop window leave on the master stream, as RGB888,
// with tlast on the window's final pixel. Other pixels are consumed silently.
// The APB port holds frame size, crop window and pixel format; write it only
// while no items are in flight.
// Throughput: one item per cycle, sustained, limited by the queue handshake.
// A windowed pixel passes through the queue slot, the product stage and the
// output register, in that order, before it appears on the master side.
// When the receiver stalls, the conversion pipeline holds and the queue of
// FIFO_DEPTH items keeps taking input until it fills; s_axis_tready then
// drops. Reset clears counters, queue and pipeline valids and loads the
// register reset values (640 x 480 frame, full-frame window, rgb888).
`default_nettype none

module crop_and_convert_to_rgb888 #(
    parameter int FIFO_DEPTH = ccrgb_pkg::FIFO_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // sample_a [7:0], sample_b [15:8], sample_c [23:16]
    input  wire         s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic        m_axis_tlast,   // window_last
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ccrgb_pkg::*;

    t_ccrgb_cfg  r_cfg;
    logic [2:0]  reg_idx;
    logic        wr_en;
    logic        push, pop, full, empty;
    t_ccrgb_item push_item, pop_item;
    logic [7:0]  red, green, blue;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= DIM_W'(640);
            r_cfg.frame_height <= DIM_W'(480);
            r_cfg.crop_left    <= '0;
            r_cfg.crop_top     <= '0;
            r_cfg.crop_right   <= DIM_W'(640);
            r_cfg.crop_bottom  <= DIM_W'(480);
            r_cfg.pixel_format <= FMT_RGB;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[DIM_W-1:0];
                REG_CROP_LEFT:    r_cfg.crop_left    <= pwdata[CNT_W-1:0];
                REG_CROP_TOP:     r_cfg.crop_top     <= pwdata[CNT_W-1:0];
                REG_CROP_RIGHT:   r_cfg.crop_right   <= pwdata[DIM_W-1:0];
                REG_CROP_BOTTOM:  r_cfg.crop_bottom  <= pwdata[DIM_W-1:0];
                REG_PIXEL_FORMAT: r_cfg.pixel_format <= t_ccrgb_fmt'(pwdata[1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = 32'(r_cfg.frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(r_cfg.frame_height);
            REG_CROP_LEFT:    prdata = 32'(r_cfg.crop_left);
            REG_CROP_TOP:     prdata = 32'(r_cfg.crop_top);
            REG_CROP_RIGHT:   prdata = 32'(r_cfg.crop_right);
            REG_CROP_BOTTOM:  prdata = 32'(r_cfg.crop_bottom);
            REG_PIXEL_FORMAT: prdata = 32'(r_cfg.pixel_format);
            default:          prdata = '0;
        endcase
    end

    ccrgb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_frame_start (s_axis_tuser),
        .i_a           (s_axis_tdata[7:0]),
        .i_b           (s_axis_tdata[15:8]),
        .i_c           (s_axis_tdata[23:16]),
        .i_full        (full),
        .o_push        (push),
        .o_item        (push_item)
    );

    ccrgb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_full  (full),
        .o_empty (empty)
    );

    ccrgb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (pop_item),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {blue, green, red};

endmodule

`default_nettype wire
